### src/stfl_pkg.sv
`default_nettype none

package stfl_pkg;

   // Line number width in decimal digits (top level default)
   localparam int NUMBER_DIGITS_DEF = 6;
   // Output bytes kept per input byte; later ones are dropped
   localparam int MAX_RESULTS       = 8;
   // Front-to-back job queue depth
   localparam int QUEUE_DEPTH       = 4;
   // Longest character expansion: M-^X
   localparam int TAIL_BYTES        = 4;

   localparam logic [3:0] MODE_PLAIN        = 4'd0;
   localparam logic [3:0] MODE_NUM_NONBLANK = 4'd1;
   localparam logic [3:0] MODE_ENDS         = 4'd2;
   localparam logic [3:0] MODE_ENDS_VIS     = 4'd3;
   localparam logic [3:0] MODE_VIS          = 4'd4;
   localparam logic [3:0] MODE_NUM_ALL      = 4'd5;
   localparam logic [3:0] MODE_SQUEEZE      = 4'd6;
   localparam logic [3:0] MODE_TABS         = 4'd7;
   localparam logic [3:0] MODE_TABS_VIS     = 4'd8;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_UPPER_I = 8'h49;
   localparam logic [7:0] CH_UPPER_M = 8'h4D;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_DEL    = 8'h7F;

   // Character part of one job: up to four bytes sent in order, cnt is 1..4
   typedef struct packed {
      logic [TAIL_BYTES-1:0][7:0] bytes;
      logic [2:0]                 cnt;
   } tail_type;

endpackage

`default_nettype wire

### src/cat_text_stream_filter_core.sv
// Path: a byte transferred at one clock edge is registered in the job queue,
//   and its first output byte is then registered in the output register.
// Rate: one input byte per cycle while each expands to one output byte and
//   rsp_stall is low; an N-byte expansion holds the output side until all N are sent.
// Reset (synchronous, active high): mode plain, line number 1, line start set.
`default_nettype none

module cat_text_stream_filter_core import stfl_pkg::*; #(
   parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF,
   parameter int QUEUE_SLOTS   = QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // configuration: filter_mode
   input  wire logic       csr_wr_en,
   input  wire logic [3:0] csr_wr_data,
   // input byte channel
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   // output byte channel
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_run_last
);

   localparam int BCD_W  = 4 * NUMBER_DIGITS;
   localparam int TAIL_W = $bits(tail_type);
   localparam int JOB_W  = 1 + BCD_W + TAIL_W;

   // Front side: classify each byte and update line state at transfer time
   logic             push;
   logic             push_num_en;
   logic [BCD_W-1:0] push_bcd;
   tail_type         push_tail;

   // Job queue between the two sides
   logic             queue_full;
   logic             head_valid;
   logic [JOB_W-1:0] head_data;
   logic             pop;

   // Back side view of the queue head
   logic             head_num_en;
   logic [BCD_W-1:0] head_bcd;
   tail_type         head_tail;

   // Hold the input only when the job queue has no free slot; the back side
   // drains it independently of the front side.
   assign req_stall = queue_full;

   stfl_front #(
      .NUMBER_DIGITS (NUMBER_DIGITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .queue_full  (queue_full),
      .push        (push),
      .push_num_en (push_num_en),
      .push_bcd    (push_bcd),
      .push_tail   (push_tail)
   );

   // A job carries the number flag, the line number snapshot taken before
   // advancing it, and the character expansion.
   stfl_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_SLOTS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({push_num_en, push_bcd, push_tail}),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   assign head_num_en = head_data[JOB_W-1];
   assign head_bcd    = head_data[TAIL_W +: BCD_W];
   assign head_tail   = head_data[TAIL_W-1:0];

   // Back side: walk the job one output byte per transfer, mark the last
   stfl_back #(
      .NUMBER_DIGITS (NUMBER_DIGITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_num_en  (head_num_en),
      .head_bcd     (head_bcd),
      .head_tail    (head_tail),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

endmodule

`default_nettype wire

### src/stfl_front.sv
`default_nettype none

module stfl_front import stfl_pkg::*; #(
   parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [3:0]                 csr_wr_data,
   input  wire logic                       req_valid,
   input  wire logic [7:0]                 req_in_byte,
   input  wire logic                       queue_full,
   output logic                            push,
   output logic                            push_num_en,
   output logic [4*NUMBER_DIGITS-1:0]      push_bcd,
   output tail_type                        push_tail
);

   localparam int BCD_W = 4 * NUMBER_DIGITS;

   logic [3:0]       mode_ff;
   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic             at_start_ff, at_start_in;
   logic [1:0]       nl_run_ff, nl_run_in;

   logic     accept;
   logic     is_nl;
   logic     num_en;
   logic     keep;
   tail_type tail;

   function automatic tail_type one_byte(input logic [7:0] a);
      tail_type t;
      t          = '0;
      t.bytes[0] = a;
      t.cnt      = 3'd1;
      return t;
   endfunction

   function automatic tail_type two_bytes(input logic [7:0] a, input logic [7:0] b);
      tail_type t;
      t          = '0;
      t.bytes[0] = a;
      t.bytes[1] = b;
      t.cnt      = 3'd2;
      return t;
   endfunction

   // Caret / M- notation; ends puts $ before newline, tabs shows tab as ^I
   function automatic tail_type vis_tail(input logic [7:0] c, input logic ends,
                                         input logic tabs);
      tail_type   t;
      logic [7:0] lo;
      t  = '0;
      lo = {1'b0, c[6:0]};
      if (c[7]) begin
         t.bytes[0] = CH_UPPER_M;
         t.bytes[1] = CH_DASH;
         if (lo < 8'd32) begin
            t.bytes[2] = CH_CARET;
            t.bytes[3] = lo + 8'd64;
            t.cnt      = 3'd4;
         end else if (lo == CH_DEL) begin
            t.bytes[2] = CH_CARET;
            t.bytes[3] = CH_QUEST;
            t.cnt      = 3'd4;
         end else begin
            t.bytes[2] = lo;
            t.cnt      = 3'd3;
         end
      end else if (c >= 8'd32 && c <= 8'd126) begin
         t = one_byte(c);
      end else if (c == CH_DEL) begin
         t = two_bytes(CH_CARET, CH_QUEST);
      end else if (c == CH_TAB) begin
         t = tabs ? two_bytes(CH_CARET, CH_UPPER_I) : one_byte(c);
      end else if (c == CH_NL) begin
         t = ends ? two_bytes(CH_DOLLAR, c) : one_byte(c);
      end else begin
         t = two_bytes(CH_CARET, c + 8'd64);
      end
      return t;
   endfunction

   // Saturating decimal increment
   function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
      logic [BCD_W-1:0] r;
      logic             carry;
      logic             all9;
      logic [3:0]       d;
      r     = v;
      all9  = 1'b1;
      carry = 1'b1;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         d = v[4*i +: 4];
         if (d != 4'd9) all9 = 1'b0;
         if (carry) begin
            if (d >= 4'd9) begin
               r[4*i +: 4] = 4'd0;
            end else begin
               r[4*i +: 4] = d + 4'd1;
               carry       = 1'b0;
            end
         end
      end
      return all9 ? v : r;
   endfunction

   function automatic logic bcd_ok(input logic [BCD_W-1:0] v);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         if (v[4*i +: 4] > 4'd9) ok = 1'b0;
      end
      return ok;
   endfunction

   always_comb begin
      is_nl  = (req_in_byte == CH_NL);
      tail   = one_byte(req_in_byte);
      num_en = 1'b0;
      keep   = 1'b1;
      case (mode_ff)
         MODE_NUM_NONBLANK: begin
            num_en = at_start_ff && !is_nl;
         end
         MODE_ENDS: begin
            if (is_nl) tail = two_bytes(CH_DOLLAR, req_in_byte);
         end
         MODE_ENDS_VIS: begin
            tail = vis_tail(req_in_byte, 1'b1, 1'b0);
         end
         MODE_VIS: begin
            tail = vis_tail(req_in_byte, 1'b0, 1'b0);
         end
         MODE_NUM_ALL: begin
            num_en = at_start_ff;
         end
         MODE_SQUEEZE: begin
            // drop every newline after the second in a row
            keep = !(is_nl && nl_run_ff == 2'd2);
         end
         MODE_TABS: begin
            if (req_in_byte == CH_TAB) tail = two_bytes(CH_CARET, CH_UPPER_I);
         end
         MODE_TABS_VIS: begin
            tail = vis_tail(req_in_byte, 1'b0, 1'b1);
         end
         default: begin
            tail = one_byte(req_in_byte);
         end
      endcase

      accept = req_valid && !queue_full;
      push   = accept && keep;

      at_start_in = at_start_ff;
      nl_run_in   = nl_run_ff;
      bcd_in      = bcd_ff;
      if (accept) begin
         at_start_in = is_nl;
         if (is_nl) begin
            nl_run_in = (nl_run_ff == 2'd2) ? 2'd2 : nl_run_ff + 2'd1;
         end else begin
            nl_run_in = 2'd0;
         end
         if (num_en) bcd_in = bcd_inc(bcd_ff);
      end
   end

   assign push_num_en = num_en;
   assign push_bcd    = bcd_ff;
   assign push_tail   = tail;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_PLAIN;
         bcd_ff      <= BCD_W'(1);
         at_start_ff <= 1'b1;
         nl_run_ff   <= 2'd1;
      end else begin
         if (csr_wr_en) mode_ff <= csr_wr_data;
         bcd_ff      <= bcd_in;
         at_start_ff <= at_start_in;
         nl_run_ff   <= nl_run_in;
      end
   end

   a_bcd_digits: assert property (@(posedge clock) disable iff (reset)
      bcd_ok(bcd_ff))
      else $error("line number holds a non-decimal digit");

   a_squeeze_drop: assert property (@(posedge clock) disable iff (reset)
      (accept && mode_ff == MODE_SQUEEZE && is_nl && nl_run_ff == 2'd2) |-> !push)
      else $error("squeezed newline was queued");

   a_run_range: assert property (@(posedge clock) disable iff (reset)
      nl_run_ff != 2'd3)
      else $error("newline run count out of range");

endmodule

`default_nettype wire

### src/stfl_queue.sv
`default_nettype none

module stfl_queue import stfl_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic                  full,
   output logic                  head_valid,
   output logic [WIDTH-1:0]      head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? wrap_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("job queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid))
      else $error("job queue read while empty");

endmodule

`default_nettype wire

### src/stfl_back.sv
`default_nettype none

module stfl_back import stfl_pkg::*; #(
   parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       head_valid,
   input  wire logic                       head_num_en,
   input  wire logic [4*NUMBER_DIGITS-1:0] head_bcd,
   input  wire tail_type                   head_tail,
   output logic                            pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_run_last
);

   localparam logic [4:0] NUM_DIG = 5'(NUMBER_DIGITS);
   localparam logic [4:0] NUM_LEN = 5'(NUMBER_DIGITS + 1);
   localparam logic [4:0] CAP     = 5'(MAX_RESULTS);
   localparam int         POS_W   = $clog2(MAX_RESULTS);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_last_ff, rsp_last_in;

   logic                     load;
   logic [4:0]               pos5;
   logic [4:0]               total;
   logic [4:0]               limit;
   logic                     is_last;
   logic [NUMBER_DIGITS-1:0] lead;
   logic                     zero_run;
   logic [3:0]               sel_digit;
   logic                     sel_lead;
   logic [4:0]               tail_pos;
   logic [7:0]               next_byte;

   always_comb begin
      // output register is free or drains this cycle
      load = !rsp_valid_ff || !rsp_stall;
      pos5 = 5'(pos_ff);

      total   = head_num_en ? NUM_LEN + {2'b00, head_tail.cnt} : {2'b00, head_tail.cnt};
      limit   = (total > CAP) ? CAP : total;
      is_last = (pos5 + 5'd1 == limit);

      // blank out leading zeros, most significant digit first
      zero_run = 1'b1;
      for (int j = 0; j < NUMBER_DIGITS; j++) begin
         zero_run = zero_run && (head_bcd[4*(NUMBER_DIGITS-1-j) +: 4] == 4'd0);
         lead[j]  = zero_run && (j != NUMBER_DIGITS - 1);
      end

      sel_digit = 4'd0;
      sel_lead  = 1'b0;
      for (int j = 0; j < NUMBER_DIGITS; j++) begin
         if (pos5 == 5'(j)) begin
            sel_digit = head_bcd[4*(NUMBER_DIGITS-1-j) +: 4];
            sel_lead  = lead[j];
         end
      end

      tail_pos = head_num_en ? pos5 - NUM_LEN : pos5;

      if (head_num_en && pos5 < NUM_DIG) begin
         next_byte = sel_lead ? CH_SPACE : CH_ZERO + {4'b0000, sel_digit};
      end else if (head_num_en && pos5 == NUM_DIG) begin
         next_byte = CH_TAB;
      end else begin
         next_byte = head_tail.bytes[tail_pos[1:0]];
      end

      pop          = head_valid && load && is_last;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            rsp_byte_in = next_byte;
            rsp_last_in = is_last;
            pos_in      = is_last ? '0 : pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_run_last = rsp_last_ff;

   a_pop_on_load: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_valid_ff && rsp_last_ff && pos_ff == '0))
      else $error("job retired without its last byte in the output register");

   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      (head_valid && load && !is_last) |=> (pos_ff == $past(pos_ff) + POS_W'(1)))
      else $error("expansion position did not advance");

endmodule

`default_nettype wire
